// ----- src/srtk_pkg.sv -----
`default_nettype none
package srtk_pkg;

    typedef struct packed {
        logic signed [31:0] id;
        logic signed [31:0] key;
        logic signed [31:0] incident;
        logic               urgent;
        logic [2:0]         tier;
    } t_row;

    typedef struct packed {
        logic write_new;
        logic shift;
    } t_cell_ctl;

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_FIND   = 2'd1;
    localparam logic [1:0] FN_READ   = 2'd2;
    localparam logic [1:0] FN_CLEAR  = 2'd3;

    localparam logic [3:0] ST_INSERTED  = 4'd0;
    localparam logic [3:0] ST_UPDATED   = 4'd1;
    localparam logic [3:0] ST_DROPPED   = 4'd2;
    localparam logic [3:0] ST_ZERO_ID   = 4'd3;
    localparam logic [3:0] ST_FOUND     = 4'd4;
    localparam logic [3:0] ST_NOT_FOUND = 4'd5;
    localparam logic [3:0] ST_READ_OK   = 4'd6;
    localparam logic [3:0] ST_ROW_EMPTY = 4'd7;
    localparam logic [3:0] ST_CLEARED   = 4'd8;

endpackage
`default_nettype wire

// ----- src/sorted_topk_list_with_dedupe_core.sv -----
`default_nettype none
// sorted top-k list with de-duplication by id
// input channel: i_in_valid / o_in_stall with the operation fields; an item
// is taken at a clock edge where i_in_valid is high and o_in_stall is low
// output channel: o_out_valid / i_out_stall, one result item per input item
// the list is a row of CAPACITY cells, each holding one entry; on insert the
// cells below the insertion point take the entry of their upper neighbor
// the per-cell id and key compares are registered in the compare step; the
// apply step then applies the shift or update and loads the result register
// a new item is taken only once the previous one has left the apply step;
// o_in_stall is high while an item is in flight
// when the receiver stalls, the result waits in the output register; a new
// item is still taken, and its apply step waits until the register is free
// reset (synchronous, active low) empties the list and drops any pending
// result; row contents are not cleared and are read only once written
module sorted_topk_list_with_dedupe_core #(
    parameter int CAPACITY = 32
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire         [1:0]  i_func,
    input  wire  signed [31:0] i_entry_id,
    input  wire  signed [31:0] i_sort_key,
    input  wire  signed [31:0] i_incident_ref,
    input  wire                i_urgent_flag,
    input  wire         [2:0]  i_relevance_tier,
    input  wire         [4:0]  i_row_select,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic        [3:0]  o_status,
    output logic        [4:0]  o_row_index,
    output logic        [5:0]  o_entry_count,
    output logic signed [31:0] o_out_id,
    output logic signed [31:0] o_out_key,
    output logic signed [31:0] o_out_incident,
    output logic               o_out_urgent,
    output logic        [2:0]  o_out_tier
);
    import srtk_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int SW   = (CW > 5) ? CW : 5;
    localparam int NSEL = (CAPACITY < 32) ? CAPACITY : 32;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [1:0]      r_func;
    logic [4:0]      r_sel;
    t_row            r_new;
    t_row            r_rd;

    logic            r_out_valid;
    logic [3:0]      r_status;
    logic [4:0]      r_row_index;
    t_row            r_out_row;

    t_row            w_row [CAPACITY];
    t_cell_ctl       w_ctl [CAPACITY];
    logic [CAPACITY-1:0] w_hit;
    logic [CAPACITY-1:0] w_less;

    logic                hit_any, less_any;
    logic [CAPACITY-1:0] hit_first, less_first, hit_before, less_before;
    logic [IW-1:0]       hit_idx, less_idx;

    logic in_acc, out_free, apply, do_write, cmp_en;
    t_row rd_mux;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign apply      = (r_state == S_APPLY) && out_free;
    assign cmp_en     = (r_state == S_CMP);
    assign do_write   = apply && (r_func == FN_INSERT) && (r_new.id != 32'sd0);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_row prev;
        if (g == 0) begin : g_first
            assign prev = r_new;
        end else begin : g_rest
            assign prev = w_row[g-1];
        end

        always_comb begin
            w_ctl[g].shift = do_write && !hit_any && less_before[g];
            if (hit_any) begin
                w_ctl[g].write_new = do_write && hit_first[g];
            end else if (less_any) begin
                w_ctl[g].write_new = do_write && less_first[g];
            end else begin
                w_ctl[g].write_new = do_write && (CW'(g) == r_count);
            end
        end

        srtk_cell u_cell (
            .i_clk  (i_clk),
            .i_cmp  (cmp_en),
            .i_occ  (CW'(g) < r_count),
            .i_new  (r_new),
            .i_prev (prev),
            .i_ctl  (w_ctl[g]),
            .o_row  (w_row[g]),
            .o_hit  (w_hit[g]),
            .o_less (w_less[g])
        );
    end

    srtk_pick #(.N(CAPACITY), .IW(IW)) u_pick_hit (
        .i_vec    (w_hit),
        .o_any    (hit_any),
        .o_first  (hit_first),
        .o_before (hit_before),
        .o_index  (hit_idx)
    );

    srtk_pick #(.N(CAPACITY), .IW(IW)) u_pick_less (
        .i_vec    (w_less),
        .o_any    (less_any),
        .o_first  (less_first),
        .o_before (less_before),
        .o_index  (less_idx)
    );

    always_comb begin
        rd_mux = '0;
        for (int i = 0; i < NSEL; i++) begin
            if (r_sel == 5'(i)) begin
                rd_mux = rd_mux | w_row[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func         <= i_func;
            r_sel          <= i_row_select;
            r_new.id       <= i_entry_id;
            r_new.key      <= (i_sort_key == 32'sd0) ? i_entry_id : i_sort_key;
            r_new.incident <= i_incident_ref;
            r_new.urgent   <= i_urgent_flag;
            r_new.tier     <= i_relevance_tier;
        end
        if (cmp_en) begin
            r_rd <= rd_mux;
        end
    end

    logic [3:0]    n_status;
    logic [4:0]    n_row_index;
    logic [CW-1:0] n_count;
    t_row          n_out_row;

    always_comb begin
        n_status    = ST_CLEARED;
        n_row_index = '0;
        n_count     = r_count;
        n_out_row   = '0;
        case (r_func)
            FN_INSERT: begin
                if (r_new.id == 32'sd0) begin
                    n_status = ST_ZERO_ID;
                end else if (hit_any) begin
                    n_status    = ST_UPDATED;
                    n_row_index = 5'(hit_idx);
                end else if (less_any || (r_count < CW'(CAPACITY))) begin
                    n_status    = ST_INSERTED;
                    n_row_index = less_any ? 5'(less_idx) : 5'(r_count);
                    if (r_count < CW'(CAPACITY)) begin
                        n_count = r_count + CW'(1);
                    end
                end else begin
                    n_status = ST_DROPPED;
                end
            end
            FN_FIND: begin
                if (hit_any) begin
                    n_status    = ST_FOUND;
                    n_row_index = 5'(hit_idx);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            FN_READ: begin
                if (SW'(r_sel) < SW'(r_count)) begin
                    n_status    = ST_READ_OK;
                    n_row_index = r_sel;
                    n_out_row   = r_rd;
                end else begin
                    n_status = ST_ROW_EMPTY;
                end
            end
            FN_CLEAR: begin
                n_status = ST_CLEARED;
                n_count  = '0;
            end
            default: begin
                n_status = ST_CLEARED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply) begin
            r_status    <= n_status;
            r_row_index <= n_row_index;
            r_out_row   <= n_out_row;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_row_index    = r_row_index;
    assign o_entry_count  = 6'(r_count);
    assign o_out_id       = r_out_row.id;
    assign o_out_key      = r_out_row.key;
    assign o_out_incident = r_out_row.incident;
    assign o_out_urgent   = r_out_row.urgent;
    assign o_out_tier     = r_out_row.tier;

    logic [CAPACITY-1:0] w_write_vec;
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_write_vec[i] = w_ctl[i].write_new;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_write_vec))
        else $error("more than one cell loads the new entry");

    a_count_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_APPLY) |=> $stable(r_count))
        else $error("entry count changed outside the apply step");

    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_CMP))
        else $error("accepted item did not enter the compare step");

    a_unique_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> ((w_hit & hit_before) == '0))
        else $error("id matches more than one row");

endmodule
`default_nettype wire

// ----- src/srtk_cell.sv -----
`default_nettype none
module srtk_cell (
    input  wire                    i_clk,
    input  wire                    i_cmp,
    input  wire                    i_occ,
    input  srtk_pkg::t_row         i_new,
    input  srtk_pkg::t_row         i_prev,
    input  srtk_pkg::t_cell_ctl    i_ctl,
    output srtk_pkg::t_row         o_row,
    output logic                   o_hit,
    output logic                   o_less
);
    import srtk_pkg::*;

    t_row r_row;
    logic r_hit;
    logic r_less;

    always_ff @(posedge i_clk) begin
        if (i_cmp) begin
            r_hit  <= i_occ && (r_row.id == i_new.id);
            r_less <= i_occ && (i_new.key > r_row.key);
        end
        if (i_ctl.write_new) begin
            r_row <= i_new;
        end else if (i_ctl.shift) begin
            r_row <= i_prev;
        end
    end

    assign o_row  = r_row;
    assign o_hit  = r_hit;
    assign o_less = r_less;

endmodule
`default_nettype wire

// ----- src/srtk_pick.sv -----
`default_nettype none
module srtk_pick #(
    parameter int N  = 32,
    parameter int IW = $clog2(N)
) (
    input  wire  [N-1:0]  i_vec,
    output logic          o_any,
    output logic [N-1:0]  o_first,
    output logic [N-1:0]  o_before,
    output logic [IW-1:0] o_index
);
    localparam int LV = $clog2(N);

    logic [N-1:0] p [0:LV];

    always_comb begin
        p[0] = i_vec;
        for (int l = 0; l < LV; l++) begin
            for (int i = 0; i < N; i++) begin
                if (i >= (1 << l)) begin
                    p[l+1][i] = p[l][i] | p[l][i - (1 << l)];
                end else begin
                    p[l+1][i] = p[l][i];
                end
            end
        end
    end

    assign o_any    = p[LV][N-1];
    assign o_before = {p[LV][N-2:0], 1'b0};
    assign o_first  = i_vec & ~o_before;

    always_comb begin
        o_index = '0;
        for (int i = 0; i < N; i++) begin
            if (o_first[i]) begin
                o_index = o_index | IW'(i);
            end
        end
    end

endmodule
`default_nettype wire
